// File: rtl/binary_classifier_metrics_auc_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the metrics block
// ----------------------------------------------------------------------------
`ifndef BINARY_CLASSIFIER_METRICS_AUC_MACROS_SVH
`define BINARY_CLASSIFIER_METRICS_AUC_MACROS_SVH

// condition must hold at every edge out of reset
`define BCM_CHECK(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BCM_CHECK_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/bcm_pkg.sv
// ----------------------------------------------------------------------------
// bcm_pkg
// Constants, state encoding and control structs of the metrics block.
// ----------------------------------------------------------------------------
package bcm_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int SCORE_W   = 16;
  localparam int RAM_W     = SCORE_W + 1;
  localparam int Q_BITS    = 16;
  localparam int DEN_W     = 2 * CNT_W + 1;
  localparam int DU_W      = 20;
  localparam int DIV_CNT_W = $clog2(Q_BITS + 1);
  localparam logic [SCORE_W-1:0] THR_RESET = SCORE_W'(32768);

  // one-hot sequencer states
  typedef enum logic [9:0] {
    S_LOAD    = 10'b00_0000_0001,
    S_OUT_RD  = 10'b00_0000_0010,
    S_OUT_LAT = 10'b00_0000_0100,
    S_INNER   = 10'b00_0000_1000,
    S_DRAIN   = 10'b00_0001_0000,
    S_NEXT    = 10'b00_0010_0000,
    S_MUL     = 10'b00_0100_0000,
    S_DIV_ACC = 10'b00_1000_0000,
    S_DIV_AUC = 10'b01_0000_0000,
    S_RESULT  = 10'b10_0000_0000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic sweep_clr;
    logic rd_i;
    logic lat_i;
    logic rd_j;
    logic i_inc;
    logic mul;
    logic div_acc;
    logic div_auc;
    logic acc_save;
    logic auc_save;
    logic set_done;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic room;
    logic i_last;
    logic j_last;
    logic lab_i;
    logic div_done;
  } status_t;

endpackage

// File: rtl/binary_classifier_metrics_auc.sv
// ----------------------------------------------------------------------------
// binary_classifier_metrics_auc
// Confusion-matrix counts, accuracy and Mann-Whitney ROC AUC of a scored set.
// ----------------------------------------------------------------------------
// Input words (score, label, last) are taken one per cycle on in_valid while
// in_stall is low and written into a 1024-entry store; words beyond capacity
// are dropped and flagged. The word with last set ends the set: in_stall then
// rises while the block sweeps the store. Each stored item is read once and
// classified; every negative item is compared with all n items (one store
// read per cycle). The compare sweep over the single store read port
// dominates the time from the last word to out_valid; two serial
// divisions give accuracy and auc.
// One result word is held on the outputs with out_valid until out_stall is
// low; the set then clears and loading resumes the next cycle. A stalled
// result holds steady. The user must write decision_threshold through
// cfg_we and cfg_wdata only while the block is idle; the block does not
// enforce this. Synchronous reset returns to loading with an empty set and
// threshold 0.5.
// ----------------------------------------------------------------------------
module binary_classifier_metrics_auc
  import bcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [SCORE_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SCORE_W-1:0]   score,
  input  logic                 label,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CNT_W-1:0]     true_pos,
  output logic [CNT_W-1:0]     true_neg,
  output logic [CNT_W-1:0]     false_pos,
  output logic [CNT_W-1:0]     false_neg,
  output logic [CNT_W-1:0]     item_total,
  output logic [Q_BITS-1:0]    accuracy,
  output logic                 accuracy_valid,
  output logic [Q_BITS-1:0]    auc,
  output logic [DU_W-1:0]      doubled_u_statistic,
  output logic                 auc_valid,
  output logic                 overflowed
);

  cmd_t    cmd;
  status_t status;

  bcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bcm_datapath u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .score               (score),
    .label               (label),
    .true_pos            (true_pos),
    .true_neg            (true_neg),
    .false_pos           (false_pos),
    .false_neg           (false_neg),
    .item_total          (item_total),
    .accuracy            (accuracy),
    .accuracy_valid      (accuracy_valid),
    .auc                 (auc),
    .doubled_u_statistic (doubled_u_statistic),
    .auc_valid           (auc_valid),
    .overflowed          (overflowed)
  );

endmodule

// File: rtl/bcm_ram.sv
// ----------------------------------------------------------------------------
// bcm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bcm_datapath.sv
// ----------------------------------------------------------------------------
// bcm_datapath
// Item store, outcome counters, pairwise rank comparator and serial divider.
// ----------------------------------------------------------------------------
`include "binary_classifier_metrics_auc_macros.svh"

module bcm_datapath
  import bcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 cfg_we,
  input  logic [SCORE_W-1:0]   cfg_wdata,
  input  logic [SCORE_W-1:0]   score,
  input  logic                 label,
  output logic [CNT_W-1:0]     true_pos,
  output logic [CNT_W-1:0]     true_neg,
  output logic [CNT_W-1:0]     false_pos,
  output logic [CNT_W-1:0]     false_neg,
  output logic [CNT_W-1:0]     item_total,
  output logic [Q_BITS-1:0]    accuracy,
  output logic                 accuracy_valid,
  output logic [Q_BITS-1:0]    auc,
  output logic [DU_W-1:0]      doubled_u_statistic,
  output logic                 auc_valid,
  output logic                 overflowed
);

  logic [SCORE_W-1:0]   thr;
  logic [CNT_W-1:0]     count;
  logic                 ovf;
  logic [ADDR_W-1:0]    i, j;
  logic [SCORE_W-1:0]   si;
  logic                 cmp_v;
  logic [CNT_W-1:0]     tp, tn, fp, fn, nb, ns;
  logic [DEN_W-1:0]     du;
  logic [2*CNT_W-1:0]   prod;
  logic [DEN_W-1:0]     dv_rem, dv_den;
  logic [Q_BITS-1:0]    dv_q;
  logic [DIV_CNT_W-1:0] dv_cnt;
  logic                 dv_sat, dv_zero;
  logic [Q_BITS-1:0]    dv_result;
  logic [DEN_W:0]       dv_sh;
  logic [DEN_W-1:0]     dv_num_in, dv_den_in;
  logic [RAM_W-1:0]     rdata;
  logic [SCORE_W-1:0]   rscore;
  logic                 rlabel;
  logic                 pred;
  logic                 auc_ok;

  // item store: label above score
  bcm_ram #(.WIDTH(RAM_W), .DEPTH(MAX_ITEMS)) u_store (
    .clk   (clk),
    .we    (cmd.load && status.room),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({label, score}),
    .raddr (cmd.rd_i ? i : j),
    .rdata (rdata)
  );

  assign rscore = rdata[SCORE_W-1:0];
  assign rlabel = rdata[SCORE_W];
  assign pred   = rscore < thr;
  assign auc_ok = (nb != '0) && (ns != '0);

  // status
  assign status.room     = count < CNT_W'(MAX_ITEMS);
  assign status.i_last   = (CNT_W'(i) + CNT_W'(1)) == count;
  assign status.j_last   = (CNT_W'(j) + CNT_W'(1)) == count;
  assign status.lab_i    = rlabel;
  assign status.div_done = dv_cnt == DIV_CNT_W'(Q_BITS);

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  // load count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.set_done) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.load) begin
      if (status.room) begin
        count <= count + CNT_W'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // sweep indexes, classification and pairwise rank accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      i     <= '0;
      j     <= '0;
      cmp_v <= 1'b0;
      tp    <= '0;
      tn    <= '0;
      fp    <= '0;
      fn    <= '0;
      nb    <= '0;
      ns    <= '0;
      du    <= '0;
    end else begin
      cmp_v <= cmd.rd_j;
      if (cmd.sweep_clr) begin
        i  <= '0;
        j  <= '0;
        tp <= '0;
        tn <= '0;
        fp <= '0;
        fn <= '0;
        nb <= '0;
        ns <= '0;
        du <= '0;
      end else begin
        if (cmd.i_inc) begin
          i <= i + ADDR_W'(1);
          j <= '0;
        end
        if (cmd.rd_j) begin
          j <= j + ADDR_W'(1);
        end
        if (cmd.lat_i) begin
          si <= rscore;
          if (rlabel) begin
            ns <= ns + CNT_W'(1);
            if (pred) tp <= tp + CNT_W'(1);
            else      fn <= fn + CNT_W'(1);
          end else begin
            nb <= nb + CNT_W'(1);
            if (pred) fp <= fp + CNT_W'(1);
            else      tn <= tn + CNT_W'(1);
          end
        end
        // negative item i against each positive item j
        if (cmp_v && rlabel) begin
          if (si > rscore) begin
            du <= du + DEN_W'(2);
          end else if (si == rscore) begin
            du <= du + DEN_W'(1);
          end
        end
      end
    end
  end

  // class-count product for the auc divisor
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= nb * ns;
    end
  end

  // divider operand select
  always_comb begin
    if (cmd.div_auc) begin
      dv_num_in = du;
      dv_den_in = {prod, 1'b0};
    end else begin
      dv_num_in = DEN_W'(tp) + DEN_W'(tn);
      dv_den_in = DEN_W'(count);
    end
  end

  // restoring divider, one quotient bit per cycle
  assign dv_sh = {dv_rem, 1'b0};
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_cnt <= DIV_CNT_W'(Q_BITS);
    end else if (cmd.div_acc || cmd.div_auc) begin
      dv_rem  <= dv_num_in;
      dv_den  <= dv_den_in;
      dv_q    <= '0;
      dv_cnt  <= '0;
      dv_sat  <= dv_num_in >= dv_den_in;
      dv_zero <= dv_den_in == '0;
    end else if (!status.div_done) begin
      dv_cnt <= dv_cnt + DIV_CNT_W'(1);
      if (dv_sh >= {1'b0, dv_den}) begin
        dv_rem <= DEN_W'(dv_sh - {1'b0, dv_den});
        dv_q   <= {dv_q[Q_BITS-2:0], 1'b1};
      end else begin
        dv_rem <= dv_sh[DEN_W-1:0];
        dv_q   <= {dv_q[Q_BITS-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (dv_zero)     dv_result = '0;
    else if (dv_sat) dv_result = '1;
    else             dv_result = dv_q;
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.acc_save) begin
      accuracy       <= dv_result;
      accuracy_valid <= count != '0;
    end
    if (cmd.auc_save) begin
      auc                 <= dv_result;
      auc_valid           <= auc_ok;
      doubled_u_statistic <= auc_ok ? du[DU_W-1:0] : '0;
    end
  end

  assign true_pos   = tp;
  assign true_neg   = tn;
  assign false_pos  = fp;
  assign false_neg  = fn;
  assign item_total = count;
  assign overflowed = ovf;

  `BCM_CHECK(a_outcome_sum, (tp + tn + fp + fn) == (nb + ns), "outcome counts disagree with class counts")
  `BCM_CHECK(a_count_cap, count <= CNT_W'(MAX_ITEMS), "item count above capacity")
  `BCM_CHECK(a_div_cnt, dv_cnt <= DIV_CNT_W'(Q_BITS), "divider step count out of range")
  `BCM_CHECK_IMP(a_du_bound, cmd.mul, du <= DEN_W'(2) * DEN_W'(nb) * DEN_W'(ns), "U above 2*nb*ns")

endmodule

// File: rtl/bcm_ctrl.sv
// ----------------------------------------------------------------------------
// bcm_ctrl
// Sequencer: load phase, pairwise sweep, divisions and result handshake.
// ----------------------------------------------------------------------------
module bcm_ctrl
  import bcm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    last,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = state != S_LOAD;
  assign out_valid = state == S_RESULT;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (last) begin
            cmd.sweep_clr = 1'b1;
            state_next    = S_OUT_RD;
          end
        end
      end
      S_OUT_RD: begin
        cmd.rd_i   = 1'b1;
        state_next = S_OUT_LAT;
      end
      S_OUT_LAT: begin
        cmd.lat_i  = 1'b1;
        state_next = status.lab_i ? S_NEXT : S_INNER;
      end
      S_INNER: begin
        cmd.rd_j = 1'b1;
        if (status.j_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (status.i_last) begin
          state_next = S_MUL;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = S_OUT_RD;
        end
      end
      S_MUL: begin
        cmd.mul     = 1'b1;
        cmd.div_acc = 1'b1;
        state_next  = S_DIV_ACC;
      end
      S_DIV_ACC: begin
        if (status.div_done) begin
          cmd.acc_save = 1'b1;
          cmd.div_auc  = 1'b1;
          state_next   = S_DIV_AUC;
        end
      end
      S_DIV_AUC: begin
        if (status.div_done) begin
          cmd.auc_save = 1'b1;
          state_next   = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_stall) begin
          cmd.set_done = 1'b1;
          state_next   = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule
